FILE: hdl/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared widths, register indexes and helpers for the block-transfer clip and
// mask set-up pipeline.
// ----------------------------------------------------------------------------
package bcs_pkg;

    localparam int unsigned MAX_DIM  = 4096;
    localparam int unsigned DIM_W    = 13;
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned WIDE_W   = 19;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned BYTES_W  = 10;
    localparam int unsigned EXTRA_W  = 10;
    localparam int unsigned SKIP_W   = 9;
    localparam int unsigned MASK_W   = 8;
    localparam int unsigned SHIFT_W  = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEST_WIDTH  = 3'd0,
        REG_DEST_HEIGHT = 3'd1,
        REG_SRC_WIDTH   = 3'd2,
        REG_SRC_HEIGHT  = 3'd3,
        REG_DEST_BASE   = 3'd4,
        REG_SRC_BASE    = 3'd5
    } t_cfg_reg;

    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_DIM);

    function automatic logic [DIM_W-1:0] f_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_LIMIT) ? DIM_LIMIT : v;
    endfunction

    function automatic t_wide f_min(input t_wide a, input t_wide b);
        return (a < b) ? a : b;
    endfunction

endpackage

FILE: hdl/blit_clip_setup.sv
// ----------------------------------------------------------------------------
// blit_clip_setup
// Five-stage clip and edge-mask set-up for a one-bit-per-pixel block transfer.
// ----------------------------------------------------------------------------
// Each request word passes through five register stages: extent negation,
// origin push-in, plane clipping, masks and row-offset multiplies, and address
// sums, and one word is taken every cycle while o_ready is high; each stage
// holds its word only while the stage after it is full and stalled, so while
// a result waits at the output the empty stages behind it keep filling, and
// the input is held off only once all five stages are full. Plane sizes
// above MAX_DIM are used as MAX_DIM. Configuration must be written only
// while the pipeline is empty; the block itself does not enforce this.
module blit_clip_setup
    import bcs_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_W-1:0]    i_dest_x,
    input  logic signed [COORD_W-1:0]    i_dest_y,
    input  logic signed [COORD_W-1:0]    i_extent_x,
    input  logic signed [COORD_W-1:0]    i_extent_y,
    input  logic signed [COORD_W-1:0]    i_source_x,
    input  logic signed [COORD_W-1:0]    i_source_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_accepted,
    output logic [ADDR_W-1:0]            o_dest_addr,
    output logic [ADDR_W-1:0]            o_src_addr,
    output logic [DIM_W-1:0]             o_row_count,
    output logic [EXTRA_W-1:0]           o_extra_bytes,
    output logic [MASK_W-1:0]            o_first_mask,
    output logic [MASK_W-1:0]            o_last_mask,
    output logic signed [SHIFT_W-1:0]    o_phase_shift,
    output logic [SKIP_W-1:0]            o_dest_skip,
    output logic [SKIP_W-1:0]            o_src_skip
);

    logic [DIM_W-1:0]  r_dest_width, r_dest_height, r_src_width, r_src_height;
    logic [ADDR_W-1:0] r_dest_base, r_src_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_width  <= '0;
            r_dest_height <= '0;
            r_src_width   <= '0;
            r_src_height  <= '0;
            r_dest_base   <= '0;
            r_src_base    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEST_WIDTH:  r_dest_width  <= i_cfg_data[DIM_W-1:0];
                REG_DEST_HEIGHT: r_dest_height <= i_cfg_data[DIM_W-1:0];
                REG_SRC_WIDTH:   r_src_width   <= i_cfg_data[DIM_W-1:0];
                REG_SRC_HEIGHT:  r_src_height  <= i_cfg_data[DIM_W-1:0];
                REG_DEST_BASE:   r_dest_base   <= i_cfg_data[ADDR_W-1:0];
                REG_SRC_BASE:    r_src_base    <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] dw, dh, sw, sh;
    assign dw = f_dim(r_dest_width);
    assign dh = f_dim(r_dest_height);
    assign sw = f_dim(r_src_width);
    assign sh = f_dim(r_src_height);

    // Stage enables: a stage loads when it is empty or its word moves on.
    logic [4:0] r_v;
    logic [4:0] en;
    assign en[4] = !r_v[4] || i_ready;
    assign en[3] = !r_v[3] || en[4];
    assign en[2] = !r_v[2] || en[3];
    assign en[1] = !r_v[1] || en[2];
    assign en[0] = !r_v[0] || en[1];
    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
            if (en[3]) r_v[3] <= r_v[2];
            if (en[4]) r_v[4] <= r_v[3];
        end
    end

    // Stage 1: negative extents flip and move both origins back.
    t_wide n1_x, n1_xs, n1_cx, n1_y, n1_ys, n1_cy;
    t_wide r1_x, r1_xs, r1_cx, r1_y, r1_ys, r1_cy;
    t_wide ex, ey;

    always_comb begin
        ex    = WIDE_W'(i_extent_x);
        ey    = WIDE_W'(i_extent_y);
        n1_x  = WIDE_W'(i_dest_x);
        n1_xs = WIDE_W'(i_source_x);
        n1_cx = ex;
        n1_y  = WIDE_W'(i_dest_y);
        n1_ys = WIDE_W'(i_source_y);
        n1_cy = ey;
        if (ex < 0) begin
            n1_cx = -ex;
            n1_x  = n1_x + ex;
            n1_xs = n1_xs + ex;
        end
        if (ey < 0) begin
            n1_cy = -ey;
            n1_y  = n1_y + ey;
            n1_ys = n1_ys + ey;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_x  <= n1_x;
            r1_xs <= n1_xs;
            r1_cx <= n1_cx;
            r1_y  <= n1_y;
            r1_ys <= n1_ys;
            r1_cy <= n1_cy;
        end
    end

    // Stage 2: push both origins forward until neither is negative.
    t_wide lo_x, lo_y, off_x, off_y;
    t_wide r2_x, r2_xs, r2_cx, r2_y, r2_ys, r2_cy;
    logic  r2_ok;

    always_comb begin
        lo_x  = f_min(r1_x, r1_xs);
        lo_y  = f_min(r1_y, r1_ys);
        off_x = (lo_x < 0) ? -lo_x : '0;
        off_y = (lo_y < 0) ? -lo_y : '0;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_x  <= r1_x + off_x;
            r2_xs <= r1_xs + off_x;
            r2_cx <= r1_cx - off_x;
            r2_y  <= r1_y + off_y;
            r2_ys <= r1_ys + off_y;
            r2_cy <= r1_cy - off_y;
            r2_ok <= (off_x < r1_cx) && (off_y < r1_cy);
        end
    end

    // Stage 3: shrink the extent to fit both planes.
    t_wide mdx, msx, mdy, msy;
    logic  n3_ok;
    logic [DIM_W-1:0] r3_x, r3_xs, r3_cx, r3_y, r3_ys, r3_cy;
    logic  r3_ok;

    always_comb begin
        mdx   = WIDE_W'(dw) - r2_x;
        msx   = WIDE_W'(sw) - r2_xs;
        mdy   = WIDE_W'(dh) - r2_y;
        msy   = WIDE_W'(sh) - r2_ys;
        n3_ok = r2_ok && (mdx > 0) && (msx > 0) && (mdy > 0) && (msy > 0);
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_x  <= r2_x[DIM_W-1:0];
            r3_xs <= r2_xs[DIM_W-1:0];
            r3_y  <= r2_y[DIM_W-1:0];
            r3_ys <= r2_ys[DIM_W-1:0];
            r3_cx <= DIM_W'(f_min(f_min(r2_cx, mdx), msx));
            r3_cy <= DIM_W'(f_min(f_min(r2_cy, mdy), msy));
            r3_ok <= n3_ok;
        end
    end

    // Stage 4: edge masks, phase and the row offsets.
    logic [DIM_W-1:0]   xmax;
    logic [BYTES_W-1:0] dwb, swb;
    logic [EXTRA_W-1:0] r4_extra;
    logic [MASK_W-1:0]  r4_org, r4_ext;
    logic [SHIFT_W-1:0] r4_shift;
    logic [DIM_W+BYTES_W-1:0] r4_dprod, r4_sprod;
    logic [DIM_W-4:0]   r4_xb, r4_xsb;
    logic [DIM_W-1:0]   r4_cy;
    logic [BYTES_W-1:0] r4_dwb, r4_swb;
    logic               r4_ok;

    always_comb begin
        xmax = r3_x + r3_cx - DIM_W'(1);
        dwb  = BYTES_W'((dw + DIM_W'(7)) >> 3);
        swb  = BYTES_W'((sw + DIM_W'(7)) >> 3);
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_extra <= EXTRA_W'(xmax[DIM_W-1:3]) - EXTRA_W'(r3_x[DIM_W-1:3]);
            r4_org   <= 8'hff >> r3_x[2:0];
            r4_ext   <= 8'hff << (~xmax[2:0]);
            r4_shift <= {1'b0, r3_x[2:0]} - {1'b0, r3_xs[2:0]};
            r4_dprod <= (DIM_W+BYTES_W)'(dwb) * (DIM_W+BYTES_W)'(r3_y);
            r4_sprod <= (DIM_W+BYTES_W)'(swb) * (DIM_W+BYTES_W)'(r3_ys);
            r4_xb    <= r3_x[DIM_W-1:3];
            r4_xsb   <= r3_xs[DIM_W-1:3];
            r4_cy    <= r3_cy;
            r4_dwb   <= dwb;
            r4_swb   <= swb;
            r4_ok    <= r3_ok;
        end
    end

    // Stage 5: addresses and skips; a rejected word shows all zeros.
    logic [ADDR_W-1:0] n5_daddr, n5_saddr;
    logic [EXTRA_W-1:0] n5_first_bytes;

    always_comb begin
        n5_daddr = r_dest_base + ADDR_W'(r4_dprod) + ADDR_W'(r4_xb);
        n5_saddr = r_src_base + ADDR_W'(r4_sprod) + ADDR_W'(r4_xsb);
        n5_first_bytes = r4_extra + EXTRA_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            o_accepted    <= r4_ok;
            o_dest_addr   <= r4_ok ? n5_daddr : '0;
            o_src_addr    <= r4_ok ? n5_saddr : '0;
            o_row_count   <= r4_ok ? r4_cy : '0;
            o_extra_bytes <= r4_ok ? r4_extra : '0;
            o_first_mask  <= !r4_ok ? '0 :
                             (r4_extra == '0) ? (r4_org & r4_ext) : r4_org;
            o_last_mask   <= r4_ok ? r4_ext : '0;
            o_phase_shift <= r4_ok ? r4_shift : '0;
            o_dest_skip   <= r4_ok ? SKIP_W'(r4_dwb - n5_first_bytes) : '0;
            o_src_skip    <= r4_ok ? SKIP_W'(r4_swb - n5_first_bytes) : '0;
        end
    end

    assign o_valid = r_v[4];

endmodule

FILE: hdl/bcs_checker.sv
// ----------------------------------------------------------------------------
// bcs_checker
// Port-level checks for the block-transfer set-up pipeline, bound to the top.
// ----------------------------------------------------------------------------
module bcs_checker
    import bcs_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic                      o_accepted,
    input logic [ADDR_W-1:0]         o_dest_addr,
    input logic [ADDR_W-1:0]         o_src_addr,
    input logic [DIM_W-1:0]          o_row_count,
    input logic [EXTRA_W-1:0]        o_extra_bytes,
    input logic [MASK_W-1:0]         o_first_mask,
    input logic [MASK_W-1:0]         o_last_mask,
    input logic signed [SHIFT_W-1:0] o_phase_shift,
    input logic [SKIP_W-1:0]         o_dest_skip,
    input logic [SKIP_W-1:0]         o_src_skip
);

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> o_dest_addr == '0 && o_src_addr == '0 &&
            o_row_count == '0 && o_first_mask == '0 && o_last_mask == '0 &&
            o_dest_skip == '0 && o_src_skip == '0 && o_phase_shift == '0)
        else $error("rejected word carries nonzero fields");

    a_rows_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |-> o_row_count != '0 && o_last_mask[MASK_W-1])
        else $error("accepted word has no rows or a bad far mask");

    a_single_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted && o_extra_bytes == '0 |->
            (o_first_mask & ~o_last_mask) == '0 && o_first_mask != '0)
        else $error("single-byte row masks not merged");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_dest_addr) &&
            $stable(o_accepted))
        else $error("stalled output word changed");

endmodule

bind blit_clip_setup bcs_checker u_bcs_checker (.*);

FILE: tb/sv/blit_setup_checker.sv
// ----------------------------------------------------------------------------
// blit_setup_checker
// Watches the configuration port and both word channels of blit_clip_setup,
// predicts the clip and mask set-up of every accepted request word from its
// own copy of the plane registers, and compares each result word field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module blit_setup_checker
    import bcs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_req_valid,
    input  logic                     i_req_ready,
    input  logic [COORD_W-1:0]       i_dest_x,
    input  logic [COORD_W-1:0]       i_dest_y,
    input  logic [COORD_W-1:0]       i_extent_x,
    input  logic [COORD_W-1:0]       i_extent_y,
    input  logic [COORD_W-1:0]       i_source_x,
    input  logic [COORD_W-1:0]       i_source_y,
    input  logic                     i_res_valid,
    input  logic                     i_res_ready,
    input  logic                     i_accepted,
    input  logic [ADDR_W-1:0]        i_dest_addr,
    input  logic [ADDR_W-1:0]        i_src_addr,
    input  logic [DIM_W-1:0]         i_row_count,
    input  logic [EXTRA_W-1:0]       i_extra_bytes,
    input  logic [MASK_W-1:0]        i_first_mask,
    input  logic [MASK_W-1:0]        i_last_mask,
    input  logic [SHIFT_W-1:0]       i_phase_shift,
    input  logic [SKIP_W-1:0]        i_dest_skip,
    input  logic [SKIP_W-1:0]        i_src_skip,
    output int                       o_mismatches,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                accepted;
        logic [ADDR_W-1:0]   dest_addr;
        logic [ADDR_W-1:0]   src_addr;
        logic [DIM_W-1:0]    row_count;
        logic [EXTRA_W-1:0]  extra_bytes;
        logic [MASK_W-1:0]   first_mask;
        logic [MASK_W-1:0]   last_mask;
        logic [SHIFT_W-1:0]  phase_shift;
        logic [SKIP_W-1:0]   dest_skip;
        logic [SKIP_W-1:0]   src_skip;
    } t_setup;

    typedef struct packed {
        logic               hit;
        logic signed [63:0] d;
        logic signed [63:0] s;
        logic signed [63:0] len;
    } t_span;

    logic [DIM_W-1:0]  dest_w, dest_h, src_w, src_h;
    logic [ADDR_W-1:0] dest_base_r, src_base_r;
    t_setup            expected_setups[$];

    function automatic longint plane_dim(input logic [DIM_W-1:0] v);
        return (longint'(v) > longint'(MAX_DIM)) ? longint'(MAX_DIM) : longint'(v);
    endfunction

    // One axis: push both origins in until neither is negative, then trim the
    // length to what both planes can hold.
    function automatic t_span clip_span(input longint d, input longint s, input longint len,
                                        input longint dlim, input longint slim);
        t_span  r;
        longint lo, off, m;
        r.hit = 1'b0;
        lo    = (d < s) ? d : s;
        off   = (lo < 0) ? -lo : 0;
        r.d   = d + off;
        r.s   = s + off;
        r.len = len - off;
        if (off >= len)
            return r;
        m = dlim - r.d;
        if (m <= 0)
            return r;
        if (m < r.len)
            r.len = m;
        m = slim - r.s;
        if (m <= 0)
            return r;
        if (m < r.len)
            r.len = m;
        r.hit = 1'b1;
        return r;
    endfunction

    function automatic t_setup clip_setup(input logic signed [COORD_W-1:0] dx,
                                          input logic signed [COORD_W-1:0] dy,
                                          input logic signed [COORD_W-1:0] ex,
                                          input logic signed [COORD_W-1:0] ey,
                                          input logic signed [COORD_W-1:0] sx,
                                          input logic signed [COORD_W-1:0] sy);
        t_setup      r;
        t_span       hx, hy;
        longint      x, y, cx, cy, xs, ys, dwb, swb, xmax, extra;
        logic [15:0] edge_bits;
        r  = '0;
        x  = dx;
        y  = dy;
        cx = ex;
        cy = ey;
        xs = sx;
        ys = sy;
        if (cx < 0) begin
            cx = -cx;
            x  = x - cx;
            xs = xs - cx;
        end
        if (cy < 0) begin
            cy = -cy;
            y  = y - cy;
            ys = ys - cy;
        end
        hx = clip_span(x, xs, cx, plane_dim(dest_w), plane_dim(src_w));
        if (!hx.hit)
            return r;
        hy = clip_span(y, ys, cy, plane_dim(dest_h), plane_dim(src_h));
        if (!hy.hit)
            return r;
        x  = hx.d;
        xs = hx.s;
        cx = hx.len;
        y  = hy.d;
        ys = hy.s;
        cy = hy.len;
        dwb       = (plane_dim(dest_w) + 7) / 8;
        swb       = (plane_dim(src_w) + 7) / 8;
        xmax      = x + cx - 1;
        extra     = xmax / 8 - x / 8;
        edge_bits = 16'h00ff << (7 - xmax % 8);
        r.accepted    = 1'b1;
        r.dest_addr   = ADDR_W'(longint'(dest_base_r) + dwb * y + x / 8);
        r.src_addr    = ADDR_W'(longint'(src_base_r) + swb * ys + xs / 8);
        r.row_count   = DIM_W'(cy);
        r.extra_bytes = EXTRA_W'(extra);
        r.last_mask   = edge_bits[7:0];
        r.first_mask  = 8'hff >> (x % 8);
        if (extra == 0)
            r.first_mask = r.first_mask & r.last_mask;
        r.phase_shift = SHIFT_W'(x % 8 - xs % 8);
        r.dest_skip   = SKIP_W'(dwb - 1 - extra);
        r.src_skip    = SKIP_W'(swb - 1 - extra);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_setup want;
        if (!i_rst_n) begin
            dest_w      = '0;
            dest_h      = '0;
            src_w       = '0;
            src_h       = '0;
            dest_base_r = '0;
            src_base_r  = '0;
            expected_setups.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DEST_WIDTH:  dest_w      = i_cfg_data[DIM_W-1:0];
                    REG_DEST_HEIGHT: dest_h      = i_cfg_data[DIM_W-1:0];
                    REG_SRC_WIDTH:   src_w       = i_cfg_data[DIM_W-1:0];
                    REG_SRC_HEIGHT:  src_h       = i_cfg_data[DIM_W-1:0];
                    REG_DEST_BASE:   dest_base_r = i_cfg_data[ADDR_W-1:0];
                    REG_SRC_BASE:    src_base_r  = i_cfg_data[ADDR_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_setups.size() == 0) begin
                    $error("result word arrived with no request outstanding");
                    o_mismatches++;
                end else begin
                    want = expected_setups.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(i_accepted));
                    check_field("dest_addr", want.dest_addr, i_dest_addr);
                    check_field("src_addr", want.src_addr, i_src_addr);
                    check_field("row_count", 32'(want.row_count), 32'(i_row_count));
                    check_field("extra_bytes", 32'(want.extra_bytes), 32'(i_extra_bytes));
                    check_field("first_mask", 32'(want.first_mask), 32'(i_first_mask));
                    check_field("last_mask", 32'(want.last_mask), 32'(i_last_mask));
                    check_field("phase_shift", 32'(want.phase_shift), 32'(i_phase_shift));
                    check_field("dest_skip", 32'(want.dest_skip), 32'(i_dest_skip));
                    check_field("src_skip", 32'(want.src_skip), 32'(i_src_skip));
                end
            end
            if (i_req_valid && i_req_ready)
                expected_setups.push_back(clip_setup(i_dest_x, i_dest_y, i_extent_x,
                                                     i_extent_y, i_source_x, i_source_y));
        end
        o_pending = expected_setups.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives blit_clip_setup through a series of plane settings, from empty and
// single-pixel planes to oversized ones with wrapping base addresses, with a
// directed set of edge cases followed by random requests, random gaps on both
// channels and long output stalls; blit_setup_checker does the comparison.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bcs_pkg::*;

    localparam int LIMIT     = 300000;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN     = 12;
    localparam int PHASES    = 12;
    localparam int PER_PHASE = 60;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    logic [COORD_W-1:0]    dest_x = '0, dest_y = '0, extent_x = '0, extent_y = '0;
    logic [COORD_W-1:0]    source_x = '0, source_y = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    logic                  accepted;
    logic [ADDR_W-1:0]     dest_addr, src_addr;
    logic [DIM_W-1:0]      row_count;
    logic [EXTRA_W-1:0]    extra_bytes;
    logic [MASK_W-1:0]     first_mask, last_mask;
    logic [SHIFT_W-1:0]    phase_shift;
    logic [SKIP_W-1:0]     dest_skip, src_skip;
    int                    mismatches, pending;

    bit hold_req  = 1'b0;
    bit send_calm = 1'b0;
    int cur_dw, cur_dh, cur_sw, cur_sh;
    int cycle_count = 0;

    blit_clip_setup DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_valid       (req_valid),
        .o_ready       (req_ready),
        .i_dest_x      (dest_x),
        .i_dest_y      (dest_y),
        .i_extent_x    (extent_x),
        .i_extent_y    (extent_y),
        .i_source_x    (source_x),
        .i_source_y    (source_y),
        .o_valid       (res_valid),
        .i_ready       (res_ready),
        .o_accepted    (accepted),
        .o_dest_addr   (dest_addr),
        .o_src_addr    (src_addr),
        .o_row_count   (row_count),
        .o_extra_bytes (extra_bytes),
        .o_first_mask  (first_mask),
        .o_last_mask   (last_mask),
        .o_phase_shift (phase_shift),
        .o_dest_skip   (dest_skip),
        .o_src_skip    (src_skip)
    );

    blit_setup_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_dest_x      (dest_x),
        .i_dest_y      (dest_y),
        .i_extent_x    (extent_x),
        .i_extent_y    (extent_y),
        .i_source_x    (source_x),
        .i_source_y    (source_y),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_accepted    (accepted),
        .i_dest_addr   (dest_addr),
        .i_src_addr    (src_addr),
        .i_row_count   (row_count),
        .i_extra_bytes (extra_bytes),
        .i_first_mask  (first_mask),
        .i_last_mask   (last_mask),
        .i_phase_shift (phase_shift),
        .i_dest_skip   (dest_skip),
        .i_src_skip    (src_skip),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin : watchdog
        while (cycle_count < LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** blit_clip_setup: FAILED **");
        $finish;
    end

    // The result side stalls at random; calm windows give stretches without
    // stalls, and a hold request from the sender starts one long stall.
    initial begin : receiver
        int stall, window;
        bit calm;
        stall  = 0;
        window = 0;
        calm   = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                res_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req  = 1'b0;
                res_ready = 1'b1;
            end else if (stall > 0) begin
                res_ready = 1'b0;
                stall--;
            end else begin
                res_ready = 1'b1;
                if (window == 0) begin
                    calm   = ($urandom_range(0, 3) == 0);
                    window = 100;
                end
                window--;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (send_calm || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input int lim);
        return COORD_W'(int'($urandom_range(0, lim + 24)) - 12);
    endfunction

    function automatic logic [COORD_W-1:0] pick_extent(input int lim);
        int r, mag;
        r = $urandom_range(0, 99);
        if (r < 55)
            mag = $urandom_range(1, 16);
        else if (r < 85)
            mag = $urandom_range(1, 80);
        else if (r < 97)
            mag = $urandom_range(1, lim + 8);
        else
            mag = $urandom_range(0, 32767);
        if ($urandom_range(0, 9) < 3)
            mag = -mag;
        return COORD_W'(mag);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic set_planes(input int dw, input int dh, input int sw, input int sh,
                              input logic [ADDR_W-1:0] db, input logic [ADDR_W-1:0] sb);
        wait_idle();
        cur_dw = dw;
        cur_dh = dh;
        cur_sw = sw;
        cur_sh = sh;
        write_reg(REG_DEST_WIDTH, {19'($urandom), 13'(dw)});
        write_reg(REG_DEST_HEIGHT, {19'($urandom), 13'(dh)});
        write_reg(REG_SRC_WIDTH, {19'($urandom), 13'(sw)});
        write_reg(REG_SRC_HEIGHT, {19'($urandom), 13'(sh)});
        write_reg(REG_DEST_BASE, db);
        write_reg(REG_SRC_BASE, sb);
    endtask

    task automatic send_req(input logic [COORD_W-1:0] dx, input logic [COORD_W-1:0] dy,
                            input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                            input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                            input int gap);
        @(negedge clk);
        if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid = 1'b1;
        dest_x    = dx;
        dest_y    = dy;
        extent_x  = ex;
        extent_y  = ey;
        source_x  = sx;
        source_y  = sy;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Mostly requests that land on or near both planes; the rest are words
    // with every field drawn from the full range.
    task automatic send_random(input int gap);
        int dwl, dhl, swl, shl;
        dwl = (cur_dw > MAX_DIM) ? MAX_DIM : cur_dw;
        dhl = (cur_dh > MAX_DIM) ? MAX_DIM : cur_dh;
        swl = (cur_sw > MAX_DIM) ? MAX_DIM : cur_sw;
        shl = (cur_sh > MAX_DIM) ? MAX_DIM : cur_sh;
        if ($urandom_range(0, 99) < 15)
            send_req(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), gap);
        else
            send_req(pick_coord(dwl), pick_coord(dhl), pick_extent(dwl), pick_extent(dhl),
                     pick_coord(swl), pick_coord(shl), gap);
    endtask

    task automatic run_random(input int n, input int hold_at);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0)
                send_calm = ($urandom_range(0, 3) == 0);
            if (i == hold_at) begin
                hold_req = 1'b1;
                burst    = 24;
            end
            if (burst > 0) begin
                burst--;
                send_random(0);
            end else begin
                send_random(pick_gap());
            end
        end
    endtask

    initial begin : stimulus
        int dw, dh, sw, sh;
        cur_dw = 0;
        cur_dh = 0;
        cur_sw = 0;
        cur_sh = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Planes are empty after reset, so everything here is rejected.
        run_random(8, -1);

        set_planes(100, 50, 64, 40, 32'h0000_1000, 32'h0000_2000);
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        send_req(3, 2, 10, 5, 5, 7, pick_gap());
        send_req(9, 0, 4, 1, 2, 0, pick_gap());
        send_req(20, 10, -8, -4, 30, 20, pick_gap());
        send_req(-5, -3, 20, 10, 2, 1, pick_gap());
        send_req(-30, 0, 10, 1, 0, 0, pick_gap());
        send_req(100, 0, 5, 5, 0, 0, pick_gap());
        send_req(0, 0, 5, 5, 64, 0, pick_gap());
        send_req(0, 50, 5, 5, 0, 0, pick_gap());
        send_req(0, 0, 5, 5, 0, 40, pick_gap());
        send_req(0, 0, 0, 5, 0, 0, pick_gap());
        send_req(32767, 0, -32768, 3, 0, 0, pick_gap());
        send_req(-32768, -32768, 32767, 32767, -32768, -32768, pick_gap());
        send_req(32767, 32767, 32767, 32767, 32767, 32767, pick_gap());
        send_req(0, 0, 32767, 32767, 0, 0, pick_gap());
        send_req(1, 0, 16, 2, 7, 0, pick_gap());
        send_req(7, 0, 16, 2, 0, 0, pick_gap());
        send_req(0, 0, 8, 1, 7, 0, pick_gap());
        send_req(7, 0, 64, 1, 0, 0, pick_gap());
        send_req(0, 0, 64, 1, 0, 0, pick_gap());
        send_req(8, 0, 1, 1, 0, 0, pick_gap());
        send_req(-1, -1, -32767, -32767, -1, -1, pick_gap());
        send_req(99, 49, -1, -1, 63, 39, pick_gap());

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_planes(4096, 4096, 4096, 4096, 32'hffff_ff00, 32'hffff_fff8);
                1: set_planes(8191, 8191, 8191, 4097, 32'hffff_ffff, 32'hffff_ffff);
                2: set_planes(1, 1, 1, 1, 32'h0000_0000, 32'h8000_0000);
                3: set_planes(0, 4096, 100, 100, $urandom, $urandom);
                4: set_planes(13, 7, 23, 300, $urandom, $urandom);
                5: set_planes(4096, 1, 8, 4096, $urandom, $urandom);
                default: begin
                    dw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                     : $urandom_range(1, 300);
                    dh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                     : $urandom_range(1, 300);
                    sw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                     : $urandom_range(1, 300);
                    sh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                     : $urandom_range(1, 300);
                    set_planes(dw, dh, sw, sh, $urandom, $urandom);
                end
            endcase
            run_random(PER_PHASE, (p == 4 || p == 9) ? 10 : -1);
        end

        wait_idle();
        if (mismatches == 0)
            $display("** blit_clip_setup: PASSED **");
        else
            $display("** blit_clip_setup: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
hdl/bcs_pkg.sv
hdl/blit_clip_setup.sv
hdl/bcs_checker.sv
tb/sv/blit_setup_checker.sv
tb/sv/tb_top.sv
